### hw/rtl/ttdws_pkg.sv
package ttdws_pkg;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_PLACE = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ACT_MOVE    = 2'd0,
      ACT_ROTATE  = 2'd1,
      ACT_FORWARD = 2'd2,
      ACT_BAD     = 2'd3
   } act_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VEC_START,
      ST_VEC_ITER,
      ST_TURN,
      ST_ROT_START,
      ST_ROT_ITER,
      ST_DRIVE,
      ST_ARRIVE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_VEC  = 2'd1,
      CMD_ROT  = 2'd2
   } cmd_type;

   localparam logic [1:0] CSR_LINEAR_STEP = 2'd0;
   localparam logic [1:0] CSR_TURN_STEP   = 2'd1;
   localparam logic [1:0] CSR_ANGLE_TOL   = 2'd2;

   localparam logic [15:0] LINEAR_STEP_RST = 16'd3277;
   localparam logic [13:0] TURN_STEP_RST   = 14'd521;
   localparam logic [13:0] ANGLE_TOL_RST   = 14'd313;

   localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;

   function automatic logic [31:0] atan_tab(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   typedef struct packed {
      cmd_type     cmd;
   } cordic_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_sts_type;

endpackage

### hw/rtl/ttdws_req_if.sv
interface ttdws_req_if #(
   parameter int POS_W   = 24,
   parameter int ANGLE_W = 16
);
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [1:0]         action_type;
   logic [POS_W-1:0]   target_x;
   logic [POS_W-1:0]   target_z;
   logic [ANGLE_W-1:0] target_angle;

   modport source (output valid, kind, action_type, target_x, target_z, target_angle,
                   input ready);
   modport sink   (input valid, kind, action_type, target_x, target_z, target_angle,
                   output ready);
endinterface

### hw/rtl/ttdws_rsp_if.sv
interface ttdws_rsp_if #(
   parameter int POS_W   = 24,
   parameter int ANGLE_W = 16
);
   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   pos_x;
   logic [POS_W-1:0]   pos_z;
   logic [ANGLE_W-1:0] heading;
   logic [8:0]         grid_x;
   logic [8:0]         grid_z;
   logic               busy_res;
   logic               finished;

   modport source (output valid, pos_x, pos_z, heading, grid_x, grid_z, busy_res, finished,
                   input ready);
   modport sink   (input valid, pos_x, pos_z, heading, grid_x, grid_z, busy_res, finished,
                   output ready);
endinterface

### hw/rtl/ttdws_cordic.sv
// Shared CORDIC: vectoring (bearing) or rotation (sin/cos), one iteration per cycle.
module ttdws_cordic
   import ttdws_pkg::*;
#(
   parameter int POS_W   = 24,
   parameter int ITERS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cordic_ctl_type        ctl,
   input  logic signed [POS_W:0] vec_dx,
   input  logic signed [POS_W:0] vec_dz,
   input  logic [31:0]           rot_angle,
   input  logic [15:0]           rot_step,
   output cordic_sts_type        sts,
   output logic [31:0]           acc_out,
   output logic signed [POS_W+1:0] sin_out,
   output logic signed [POS_W+1:0] cos_out
);
   localparam int XW = POS_W + 20;
   localparam int IW = $clog2(ITERS + 1);

   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]          z_ff, z_in;
   logic [IW-1:0]        it_ff, it_in;
   logic                 mode_ff, mode_in;
   logic                 run_ff, run_in, done_ff, done_in, neg_ff, neg_in;

   logic signed [XW-1:0] xs, ys;
   logic [31:0]          at;
   logic                 dir;
   logic [47:0]          prod;
   logic [31:0]          ra;
   logic signed [XW-1:0] xr, yr;

   assign xs = x_ff >>> it_ff;
   assign ys = y_ff >>> it_ff;
   assign at = atan_tab(5'(it_ff));
   assign dir = mode_ff ? ~z_ff[31] : (y_ff > 0);
   assign prod = 48'(rot_step) * 48'(CORDIC_GAIN);

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; it_in = it_ff;
      mode_in = mode_ff; run_in = run_ff; done_in = 1'b0; neg_in = neg_ff;
      ra = rot_angle;
      if (ctl.cmd == CMD_VEC) begin
         mode_in = 1'b0; run_in = 1'b1; it_in = '0; neg_in = 1'b0;
         if (vec_dz < 0) begin
            x_in = -XW'(vec_dz); y_in = -XW'(vec_dx); z_in = 32'h80000000;
         end else begin
            x_in = XW'(vec_dz); y_in = XW'(vec_dx); z_in = '0;
         end
      end else if (ctl.cmd == CMD_ROT) begin
         mode_in = 1'b1; run_in = 1'b1; it_in = '0; neg_in = 1'b0;
         if (ra > 32'h40000000 && ra < 32'hC0000000) begin
            ra = ra - 32'h80000000; neg_in = 1'b1;
         end
         z_in = ra;
         x_in = XW'(prod[47:16]);
         y_in = '0;
      end else if (run_ff) begin
         if (mode_ff ? dir : dir) begin
            if (mode_ff) begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
            end
         end else begin
            if (mode_ff) begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
            end else begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
            end
         end
         it_in = it_ff + 1'b1;
         if (it_ff == IW'(ITERS - 1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; it_ff <= it_in;
      mode_ff <= mode_in; neg_ff <= neg_in;
   end

   assign xr = (x_ff + XW'(32768)) >>> 16;
   assign yr = (y_ff + XW'(32768)) >>> 16;
   assign sin_out = neg_ff ? -(POS_W+2)'(yr) : (POS_W+2)'(yr);
   assign cos_out = neg_ff ? -(POS_W+2)'(xr) : (POS_W+2)'(xr);
   assign acc_out = z_ff;
   assign sts.busy = run_ff;
   assign sts.done = done_ff;
endmodule

### hw/rtl/turn_then_drive_waypoint_stepper.sv
// A load, place or idle tick is answered straight from idle; a MOVE turning tick runs a
// vectoring pass on the shared CORDIC (skipped at the goal point), then turn and arrive;
// a driving tick runs a rotation pass, then drive and arrive; a ROTATE tick only turns.
// One request at a time. Result held in an output register until taken.
// Reset (synchronous, active high): pose zero, no action, registers to defaults.
module turn_then_drive_waypoint_stepper
   import ttdws_pkg::*;
#(
   parameter int POS_INT_BITS  = 8,
   parameter int POS_FRAC_BITS = 16,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_ITERS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   ttdws_req_if.sink   req,
   ttdws_rsp_if.source rsp
);
   localparam int PW = POS_INT_BITS + POS_FRAC_BITS;
   localparam int AW = ANGLE_BITS;
   localparam logic signed [PW+1:0] PMAX = (PW+2)'((64'sd1 <<< (PW-1)) - 1);
   localparam logic signed [PW+1:0] PMIN = -PMAX - 1;

   state_type state_ff, state_in;
   logic [15:0] lin_ff;
   logic [13:0] tstep_ff, tol_ff;
   logic signed [PW-1:0] px_ff, px_in, pz_ff, pz_in, gx_ff, gz_ff;
   logic [AW-1:0] hd_ff, hd_in, gh_ff, brg_ff, brg_in;
   act_type atype_ff;
   logic active_ff, active_in, turning_ff, turning_in, fin_ff, fin_in;
   logic rvalid_ff, rvalid_in;

   cordic_ctl_type cctl;
   cordic_sts_type csts;
   logic [31:0] acc;
   logic signed [PW+1:0] sn, cs;

   ttdws_cordic #(.POS_W(PW), .ITERS(CORDIC_ITERS)) u_cordic (
      .clock, .reset, .ctl(cctl),
      .vec_dx((PW+1)'(gx_ff) - (PW+1)'(px_ff)),
      .vec_dz((PW+1)'(gz_ff) - (PW+1)'(pz_ff)),
      .rot_angle({hd_ff, {(32-AW){1'b0}}}),
      .rot_step(lin_ff),
      .sts(csts), .acc_out(acc), .sin_out(sn), .cos_out(cs));

   assign req.ready = (state_ff == ST_IDLE) && !rvalid_ff;

   logic accept;
   assign accept = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff <= LINEAR_STEP_RST; tstep_ff <= TURN_STEP_RST; tol_ff <= ANGLE_TOL_RST;
      end else if (csr_write) begin
         if (csr_index == CSR_LINEAR_STEP) lin_ff <= csr_data;
         if (csr_index == CSR_TURN_STEP)   tstep_ff <= csr_data[13:0];
         if (csr_index == CSR_ANGLE_TOL)   tol_ff <= csr_data[13:0];
      end
   end

   // turn toward target g
   logic [AW-1:0] tgt, dr, dl;
   logic snap;
   assign tgt = (state_ff == ST_TURN && atype_ff == ACT_MOVE) ? brg_ff : gh_ff;
   assign dr = tgt - hd_ff;
   assign dl = hd_ff - tgt;
   assign snap = ({6'd0, dr} <= (AW+6)'(tol_ff)) ||
                 ({6'd0, dr} >= (AW+6)'((64'd1 << AW) - 64'(tol_ff)));

   // arrival check
   logic signed [PW+1:0] ex, ez, ax, az;
   logic arr;
   assign ex = (PW+2)'(gx_ff) - (PW+2)'(px_ff);
   assign ez = (PW+2)'(gz_ff) - (PW+2)'(pz_ff);
   assign ax = ex[PW+1] ? -ex : ex;
   assign az = ez[PW+1] ? -ez : ez;
   assign arr = ((ax <<< 1) <= (PW+2)'(lin_ff)) && ((az <<< 1) <= (PW+2)'(lin_ff));

   logic signed [PW+1:0] sx, sz;
   assign sx = (PW+2)'(px_ff) + sn;
   assign sz = (PW+2)'(pz_ff) + cs;

   logic [32:0] brnd;
   assign brnd = {1'b0, acc} + (33'd1 << (31 - AW));

   logic load_ok;
   assign load_ok = accept && kind_type'(req.kind) == KIND_LOAD &&
                    act_type'(req.action_type) != ACT_BAD;

   always_comb begin
      state_in = state_ff;
      cctl.cmd = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && kind_type'(req.kind) == KIND_TICK && active_ff) begin
               priority case (atype_ff)
                  ACT_MOVE:   state_in = turning_ff ? ST_VEC_START : ST_ROT_START;
                  ACT_ROTATE: state_in = ST_TURN;
                  default:    state_in = ST_ROT_START;
               endcase
            end
         end
         ST_VEC_START: begin
            if (ex == 0 && ez == 0) state_in = ST_TURN;
            else state_in = ST_VEC_ITER;
         end
         ST_VEC_ITER:  if (csts.done) state_in = ST_TURN;
         ST_TURN:      state_in = (atype_ff == ACT_MOVE) ? ST_ARRIVE : ST_DONE;
         ST_ROT_START: state_in = ST_ROT_ITER;
         ST_ROT_ITER:  if (csts.done) state_in = ST_DRIVE;
         ST_DRIVE:     state_in = ST_ARRIVE;
         ST_ARRIVE:    state_in = ST_DONE;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
      if (state_ff == ST_VEC_START && !(ex == 0 && ez == 0)) cctl.cmd = CMD_VEC;
      if (state_ff == ST_ROT_START) cctl.cmd = CMD_ROT;
   end

   always_comb begin
      px_in = px_ff; pz_in = pz_ff; hd_in = hd_ff; brg_in = brg_ff;
      active_in = active_ff; turning_in = turning_ff; fin_in = fin_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) fin_in = 1'b0;
            if (load_ok) begin
               active_in = 1'b1; turning_in = 1'b1;
            end
            if (accept && kind_type'(req.kind) == KIND_PLACE) begin
               px_in = req.target_x; pz_in = req.target_z; hd_in = req.target_angle;
               turning_in = 1'b1;
            end
         end
         ST_VEC_START: brg_in = '0;
         ST_VEC_ITER: if (csts.done) brg_in = brnd[31 -: AW];
         ST_TURN: begin
            if (snap) begin
               hd_in = tgt;
               if (atype_ff == ACT_MOVE) turning_in = 1'b0;
               else fin_in = 1'b1;
            end else if (dl < dr) begin
               hd_in = hd_ff - AW'(tstep_ff);
            end else begin
               hd_in = hd_ff + AW'(tstep_ff);
            end
         end
         ST_DRIVE: begin
            px_in = (sx > PMAX) ? PMAX[PW-1:0] : (sx < PMIN) ? PMIN[PW-1:0] : sx[PW-1:0];
            pz_in = (sz > PMAX) ? PMAX[PW-1:0] : (sz < PMIN) ? PMIN[PW-1:0] : sz[PW-1:0];
         end
         ST_ARRIVE: begin
            if (arr) begin
               px_in = gx_ff; pz_in = gz_ff; fin_in = 1'b1;
               if (atype_ff == ACT_MOVE) turning_in = 1'b1;
            end
         end
         ST_DONE: if (fin_ff) active_in = 1'b0;
         default: ;
      endcase
   end

   logic go_rsp;
   assign go_rsp = (state_ff == ST_DONE) ||
                   (accept && !(kind_type'(req.kind) == KIND_TICK && active_ff));

   always_comb begin
      rvalid_in = rvalid_ff;
      if (rsp.valid && rsp.ready) rvalid_in = 1'b0;
      if (go_rsp) rvalid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rvalid_ff <= 1'b0;
         px_ff <= '0; pz_ff <= '0; hd_ff <= '0; gx_ff <= '0; gz_ff <= '0; gh_ff <= '0;
         atype_ff <= ACT_MOVE; active_ff <= 1'b0; turning_ff <= 1'b1; fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rvalid_ff <= rvalid_in;
         px_ff <= px_in; pz_ff <= pz_in; hd_ff <= hd_in; active_ff <= active_in;
         turning_ff <= turning_in; fin_ff <= fin_in;
         if (load_ok) begin
            atype_ff <= act_type'(req.action_type);
            gx_ff <= req.target_x; gz_ff <= req.target_z; gh_ff <= req.target_angle;
         end
      end
      brg_ff <= brg_in;
   end

   function automatic logic [8:0] grid(input logic signed [PW-1:0] p);
      logic signed [PW:0] v, q;
      v = (PW+1)'(p) + (PW+1)'(1 <<< (POS_FRAC_BITS - 1));
      q = v[PW] ? -((-v) >>> POS_FRAC_BITS) : (v >>> POS_FRAC_BITS);
      return q[8:0];
   endfunction

   assign rsp.valid    = rvalid_ff;
   assign rsp.pos_x    = px_ff;
   assign rsp.pos_z    = pz_ff;
   assign rsp.heading  = hd_ff;
   assign rsp.grid_x   = grid(px_ff);
   assign rsp.grid_z   = grid(pz_ff);
   assign rsp.busy_res = active_ff;
   assign rsp.finished = fin_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("accept while busy");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rvalid_ff) else $error("no response");
   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && fin_ff) |-> !active_ff) else $error("finished but busy");
endmodule
